### rtl/core/assert_macros.svh
// Assertion macros for the RTL in this folder.
// No dependencies; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/adam_pkg.sv
// Types, constants and step functions of the Adam update engine.
// No dependencies.
`timescale 1ns / 1ps

package adam_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned RemW     = 44;  // divider and root remainder
  localparam int unsigned DivW     = 43;  // divisor width
  localparam int unsigned RootW    = 40;  // Q8.32 root
  localparam int unsigned DenW     = 41;
  localparam int unsigned QSteps   = 64;
  localparam int unsigned RootSteps = 40;

  localparam logic [23:0] LrReset    = 24'd16777;
  localparam logic [23:0] Beta1Reset = 24'd15099494;
  localparam logic [23:0] Beta2Reset = 24'd16760439;
  localparam logic [31:0] EpsReset   = 32'd43;
  localparam logic [32:0] PowOne     = 33'h1_0000_0000;
  localparam logic [24:0] OneQ24     = 25'h100_0000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LR    = 2'd0,
    REG_BETA1 = 2'd1,
    REG_BETA2 = 2'd2,
    REG_EPS   = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    CMD_STEP = 1'b0,
    CMD_ELEM = 1'b1
  } cmd_e;

  // Flags that travel with an element down the pipeline
  typedef struct packed {
    logic neg;    // sign of m
    logic zero;   // m is zero
    logic fault;  // bias divisor zero
    logic zden;   // root plus epsilon zero
  } tag_t;

  // Restoring divider state: lo holds remaining dividend bits on top,
  // quotient bits enter at the bottom.
  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [63:0]     lo;
    logic [DivW-1:0] d;
    logic            sat;
  } div_t;

  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } sq_t;

  function automatic div_t div_step(input div_t s);
    div_t            r;
    logic [RemW-1:0] rem2;
    logic            ge;
    rem2  = {s.rem[RemW-2:0], s.lo[63]};
    ge    = rem2 >= {1'b0, s.d};
    r     = s;
    r.rem = ge ? rem2 - {1'b0, s.d} : rem2;
    r.lo  = {s.lo[62:0], ge};
    return r;
  endfunction

  function automatic logic [31:0] sat_q824(input logic neg, input logic [63:0] mag);
    logic [31:0] r;
    if (!neg) begin
      r = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end else begin
      r = (mag >= 64'h8000_0000) ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
    end
    return r;
  endfunction

endpackage

### rtl/core/adam_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module adam_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/adam_optimizer_update.sv
// Adam update engine: moment RAM read-modify-write, two pipelined dividers,
// pipelined root and a final pipelined divider. Uses adam_pkg, adam_ram.
// One element per cycle while the output is not stalled.
// The three 64-step dividers and the 40-step root make up most of the pipeline.
// After reset a clearing pass writes ENTRIES zero rows, one per cycle, with
// input stalled; config writes are taken throughout.
`timescale 1ns / 1ps

module adam_optimizer_update #(
  parameter int unsigned ENTRIES = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [adam_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [adam_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              cmd_i,
  input  logic [11:0]                       element_index_i,
  input  logic signed [31:0]                gradient_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [31:0]                update_value_o,
  output logic                              divisor_fault_o
);

  import adam_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Configuration and powers
  logic [23:0] lr_q, beta1_q, beta2_q;
  logic [31:0] eps_q;
  logic [32:0] pow1_q, pow2_q;
  logic [56:0] pow1_prod, pow2_prod;

  // Handshake and clearing
  logic          adv, in_acc, elem_acc;
  logic          clr_q;
  logic [AW-1:0] clr_cnt_q;

  // Moment stage
  logic                 a_valid_q;
  logic [AW-1:0]        a_addr_q;
  logic signed [31:0]   a_g_q;
  logic [63:0]          a_g2_q;
  logic [32:0]          a_d1_q, a_d2_q;
  logic                 fwd_q;
  logic [95:0]          fwd_data_q;
  logic [95:0]          rd_data, wr_data, mom_new;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic signed [31:0]   m_old, m_new;
  logic [63:0]          v_old, v_new, v_hi, v_lo;
  logic [24:0]          omb1, omb2;
  logic signed [57:0]   mp_a, mp_b;
  logic signed [58:0]   m_sum, m_shr;
  logic [31:0]          m_mag;
  logic [32:0]          d1_in, d2_in;
  logic signed [63:0]   g_sq;

  // Pipelines
  div_t diva_q [QSteps+1];
  div_t divb_q [QSteps+1];
  tag_t dtag_q [QSteps+1];
  logic dval_q [QSteps+1];

  sq_t         sq_q   [RootSteps+1];
  logic [63:0] sx_q   [RootSteps+1];
  logic [63:0] smh_q  [RootSteps+1];
  tag_t        stag_q [RootSteps+1];
  logic        sval_q [RootSteps+1];

  logic [63:0]     p_lo_q, p_hi_q;
  logic [DenW-1:0] den_q;
  tag_t            ptag_q;
  logic            pval_q;
  logic [DenW-1:0] den_d;
  logic [95:0]     prod_sum;
  div_t            divc_in;

  div_t divc_q [QSteps+1];
  tag_t ctag_q [QSteps+1];
  logic cval_q [QSteps+1];

  logic        out_valid_q, out_fault_q;
  logic [31:0] out_value_q;
  logic [63:0] fin_q, fin_mag;
  tag_t        fin_tag;

  // ---------------------------------------------------------------- control
  assign adv        = !out_valid_q || !out_stall_i || !cval_q[QSteps];
  assign in_stall_o = !adv || clr_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign elem_acc   = in_acc && (cmd_i == CMD_ELEM) &&
                      (32'(element_index_i) < 32'(ENTRIES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q    <= LrReset;
      beta1_q <= Beta1Reset;
      beta2_q <= Beta2Reset;
      eps_q   <= EpsReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LR:    lr_q    <= cfg_data_i[23:0];
        REG_BETA1: beta1_q <= cfg_data_i[23:0];
        REG_BETA2: beta2_q <= cfg_data_i[23:0];
        REG_EPS:   eps_q   <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  assign pow1_prod = pow1_q * beta1_q;
  assign pow2_prod = pow2_q * beta2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pow1_q <= PowOne;
      pow2_q <= PowOne;
    end else if (in_acc && cmd_i == CMD_STEP) begin
      pow1_q <= pow1_prod[56:24];
      pow2_q <= pow2_prod[56:24];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
      if (clr_cnt_q == AW'(ENTRIES - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------ moment RAM
  assign ram_raddr = AW'(element_index_i);
  assign ram_we    = clr_q || (a_valid_q && adv);
  assign ram_waddr = clr_q ? clr_cnt_q : a_addr_q;
  assign wr_data   = clr_q ? '0 : mom_new;

  adam_ram #(
    .Width (96),
    .Depth (ENTRIES)
  ) u_mom_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_data),
    .re_i    (elem_acc),
    .raddr_i (ram_raddr),
    .rdata_o (rd_data)
  );

  assign d1_in = PowOne - pow1_q;
  assign d2_in = PowOne - pow2_q;
  assign g_sq  = gradient_i * gradient_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      fwd_q     <= 1'b0;
    end else if (adv) begin
      a_valid_q <= elem_acc;
      // row being written this edge is not yet visible to the read
      fwd_q     <= a_valid_q && (a_addr_q == ram_raddr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (elem_acc) begin
      a_addr_q <= ram_raddr;
      a_g_q    <= gradient_i;
      a_g2_q   <= g_sq;
      a_d1_q   <= d1_in;
      a_d2_q   <= d2_in;
    end
    if (adv) begin
      fwd_data_q <= mom_new;
    end
  end

  // m occupies the upper 32 bits of a row, v the lower 64
  assign m_old = fwd_q ? fwd_data_q[95:64] : rd_data[95:64];
  assign v_old = fwd_q ? fwd_data_q[63:0]  : rd_data[63:0];
  assign omb1  = OneQ24 - 25'(beta1_q);
  assign omb2  = OneQ24 - 25'(beta2_q);
  assign mp_a  = $signed({1'b0, omb1}) * a_g_q;
  assign mp_b  = $signed({2'b0, beta1_q}) * m_old;
  assign m_sum = 59'(mp_a) + 59'(mp_b);
  assign m_shr = m_sum >>> 24;
  assign m_new = m_shr[31:0];
  assign v_hi  = 64'(omb2 * a_g2_q[63:32]) + 64'(beta2_q * v_old[63:32]);
  assign v_lo  = 64'(omb2 * a_g2_q[31:0]) + 64'(beta2_q * v_old[31:0]);
  assign v_new = {v_hi[55:0], 8'b0} + {24'b0, v_lo[63:24]};
  assign mom_new = {m_new, v_new};
  assign m_mag = m_new[31] ? (~m_new + 32'd1) : m_new;

  // ----------------------------------------------------- bias dividers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dval_q[0] <= 1'b0;
    end else if (adv) begin
      dval_q[0] <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      diva_q[0].rem <= '0;
      diva_q[0].lo  <= {m_mag, 32'b0};
      diva_q[0].d   <= DivW'(a_d1_q);
      diva_q[0].sat <= (a_d1_q == '0);
      divb_q[0].rem <= RemW'(v_new[63:32]);
      divb_q[0].lo  <= {v_new[31:0], 32'b0};
      divb_q[0].d   <= DivW'(a_d2_q);
      divb_q[0].sat <= {1'b0, v_new[63:32]} >= a_d2_q;
      dtag_q[0].neg   <= m_new[31];
      dtag_q[0].zero  <= (m_new == '0);
      dtag_q[0].fault <= (a_d1_q == '0) || (a_d2_q == '0);
      dtag_q[0].zden  <= 1'b0;
    end
  end

  for (genvar i = 0; i < QSteps; i++) begin : g_div_ab
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dval_q[i+1] <= 1'b0;
      end else if (adv) begin
        dval_q[i+1] <= dval_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        diva_q[i+1] <= div_step(diva_q[i]);
        divb_q[i+1] <= div_step(divb_q[i]);
        dtag_q[i+1] <= dtag_q[i];
      end
    end
  end

  // ------------------------------------------------------------- root
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sval_q[0] <= 1'b0;
    end else if (adv) begin
      sval_q[0] <= dval_q[QSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_q[0]   <= '0;
      sx_q[0]   <= divb_q[QSteps].sat ? '1 : divb_q[QSteps].lo;
      smh_q[0]  <= diva_q[QSteps].lo;
      stag_q[0] <= dtag_q[QSteps];
    end
  end

  for (genvar k = 0; k < RootSteps; k++) begin : g_root
    localparam int unsigned Bit = RootSteps - 1 - k;
    logic [1:0]      pair;
    logic [RemW-1:0] rem2, trial;
    logic            ge;
    if (Bit >= 8) begin : g_pair
      assign pair = sx_q[k][2*Bit-16 +: 2];
    end else begin : g_nopair
      assign pair = 2'b00;
    end
    assign rem2  = {sq_q[k].rem[RemW-3:0], pair};
    assign trial = RemW'({sq_q[k].root, 2'b01});
    assign ge    = rem2 >= trial;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sval_q[k+1] <= 1'b0;
      end else if (adv) begin
        sval_q[k+1] <= sval_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_q[k+1].rem  <= ge ? rem2 - trial : rem2;
        sq_q[k+1].root <= {sq_q[k].root[RootW-2:0], ge};
        sx_q[k+1]      <= sx_q[k];
        smh_q[k+1]     <= smh_q[k];
        stag_q[k+1]    <= stag_q[k];
      end
    end
  end

  // --------------------------------------------------- numerator product
  assign den_d = DenW'(sq_q[RootSteps].root) + DenW'(eps_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pval_q <= 1'b0;
    end else if (adv) begin
      pval_q <= sval_q[RootSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_lo_q <= smh_q[RootSteps][31:0]  * {lr_q, 8'b0};
      p_hi_q <= smh_q[RootSteps][63:32] * {lr_q, 8'b0};
      den_q  <= den_d;
      ptag_q <= '{neg:   stag_q[RootSteps].neg,
                  zero:  stag_q[RootSteps].zero,
                  fault: stag_q[RootSteps].fault,
                  zden:  (den_d == '0)};
    end
  end

  assign prod_sum    = {p_hi_q, 32'b0} + {32'b0, p_lo_q};
  assign divc_in.rem = RemW'(prod_sum[95:64]);
  assign divc_in.lo  = prod_sum[63:0];
  assign divc_in.d   = DivW'(den_q);
  assign divc_in.sat = DivW'(prod_sum[95:64]) >= DivW'(den_q);

  // ---------------------------------------------------- final divider
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cval_q[0] <= 1'b0;
    end else if (adv) begin
      cval_q[0] <= pval_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      divc_q[0] <= divc_in;
      ctag_q[0] <= ptag_q;
    end
  end

  for (genvar i = 0; i < QSteps; i++) begin : g_div_c
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cval_q[i+1] <= 1'b0;
      end else if (adv) begin
        cval_q[i+1] <= cval_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        divc_q[i+1] <= div_step(divc_q[i]);
        ctag_q[i+1] <= ctag_q[i];
      end
    end
  end

  // ------------------------------------------------------------- output
  assign fin_tag = ctag_q[QSteps];
  assign fin_q   = divc_q[QSteps].sat ? '1 : divc_q[QSteps].lo;

  always_comb begin
    if (fin_tag.fault || fin_tag.zden) begin
      fin_mag = fin_tag.zero ? '0 : '1;
    end else begin
      fin_mag = fin_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && cval_q[QSteps]) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && cval_q[QSteps]) begin
      out_value_q <= sat_q824(fin_tag.neg, fin_mag);
      out_fault_q <= fin_tag.fault;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign update_value_o  = out_value_q;
  assign divisor_fault_o = out_fault_q;

  // ---------------------------------------------------------- assertions
  `ASSERT_ALWAYS(a_no_beat_in_clear, clk_i, rst_ni, !clr_q || in_stall_o, "beat taken during clear")
  `ASSERT_ALWAYS(a_ram_we_src, clk_i, rst_ni, !ram_we || clr_q || (a_valid_q && adv), "stray moment write")
  `ASSERT_ALWAYS(a_fault_sat, clk_i, rst_ni, !(out_valid_q && out_fault_q) || out_value_q == 32'h7FFF_FFFF || out_value_q == 32'h8000_0000 || out_value_q == 32'h0, "fault result not saturated")
  `ASSERT_NEXT(a_fwd_src, clk_i, rst_ni, adv && a_valid_q && elem_acc && a_addr_q == ram_raddr, fwd_q, "missed forward")

endmodule

### verif/tb_adam_optimizer_update.sv
// Self-checking bench for adam_optimizer_update: a scoreboard class predicts each update beat.
// Depends on adam_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_adam_optimizer_update;
  import adam_pkg::*;

  localparam int unsigned Depth = 4096;
  localparam int unsigned DrainCycles = 200;  // idle wait after the scoreboard empties
  localparam int unsigned HoldCycles = 600;

  class adam_update_predictor;
    bit [23:0]          lr, b1, b2;
    bit [31:0]          eps;
    bit [32:0]          pow1, pow2;
    int                 mom1[Depth];
    bit [63:0]          mom2[Depth];
    bit [31:0]          exp_value_q[$];
    bit                 exp_fault_q[$];
    int unsigned        n_steps, n_elems, n_checked, n_faults, n_errors;

    function new();
      lr = LrReset; b1 = Beta1Reset; b2 = Beta2Reset; eps = EpsReset;
      pow1 = PowOne; pow2 = PowOne;
      foreach (mom1[i]) begin
        mom1[i] = 0;
        mom2[i] = '0;
      end
    endfunction

    function void set_reg(cfg_reg_e r, bit [31:0] d);
      case (r)
        REG_LR:    lr = d[23:0];
        REG_BETA1: b1 = d[23:0];
        REG_BETA2: b2 = d[23:0];
        default:   eps = d;
      endcase
    endfunction

    static function bit [63:0] isqrt(bit [127:0] x);
      bit [127:0] r, t;
      r = '0;
      for (int b = 41; b >= 0; b--) begin
        t = r | (128'd1 << b);
        if (t * t <= x) r = t;
      end
      return r[63:0];
    endfunction

    static function bit [31:0] sat_update(bit neg, bit [63:0] mag);
      if (!neg) return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
      return (mag >= 64'h8000_0000) ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
    endfunction

    function void note_beat(cmd_e c, bit [11:0] idx, bit signed [31:0] g);
      longint      gl, m;
      bit [63:0]   g2, v, mag, d1, d2, mhat, vhat, den;
      bit [127:0]  wide;
      bit          neg;
      if (c == CMD_STEP) begin
        n_steps++;
        pow1 = (64'(pow1) * b1) >> 24;
        pow2 = (64'(pow2) * b2) >> 24;
        return;
      end
      n_elems++;
      gl = g;
      m = ((64'sd16777216 - longint'(b1)) * gl + longint'(b1) * longint'(mom1[idx])) >>> 24;
      mom1[idx] = int'(m);
      g2 = gl * gl;
      wide = (128'(25'h100_0000 - b2) * g2 + 128'(b2) * mom2[idx]) >> 24;
      v = wide[63:0];
      mom2[idx] = v;
      neg = m < 0;
      mag = neg ? 64'(-m) : 64'(m);
      d1 = 64'h1_0000_0000 - pow1;
      d2 = 64'h1_0000_0000 - pow2;
      if (d1 == 0 || d2 == 0) begin
        n_faults++;
        exp_value_q.push_back(sat_update(neg, mag == 0 ? '0 : '1));
        exp_fault_q.push_back(1'b1);
        return;
      end
      mhat = (mag << 32) / d1;
      wide = {32'd0, v, 32'd0} / d2;
      vhat = (wide[127:64] != 0) ? '1 : wide[63:0];
      den = isqrt({48'd0, vhat, 16'd0}) + eps;
      if (den == 0) begin
        exp_value_q.push_back(sat_update(neg, mag == 0 ? '0 : '1));
      end else begin
        wide = (128'(mhat) * (64'(lr) << 8)) / den;
        exp_value_q.push_back(sat_update(neg, (wide[127:64] != 0) ? '1 : wide[63:0]));
      end
      exp_fault_q.push_back(1'b0);
    endfunction

    function void check_result(bit [31:0] val, bit fault);
      bit [31:0] ev;
      bit        ef;
      if (exp_value_q.size() == 0) begin
        $error("update beat with nothing expected: update_value %0d", $signed(val));
        n_errors++;
        return;
      end
      ev = exp_value_q.pop_front();
      ef = exp_fault_q.pop_front();
      n_checked++;
      if (val !== ev) begin
        $error("update_value: expected %0d, got %0d", $signed(ev), $signed(val));
        n_errors++;
      end
      if (fault !== ef) begin
        $error("divisor_fault: expected %0b, got %0b", ef, fault);
        n_errors++;
      end
    endfunction

    function int pending();
      return exp_value_q.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  cfg_reg_e           cfg_idx_i = REG_LR;
  logic [31:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               cmd_i = CMD_STEP;
  logic [11:0]        element_index_i = '0;
  logic signed [31:0] gradient_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] update_value_o;
  logic               divisor_fault_o;
  bit                 hold_req = 1'b0;

  adam_update_predictor sb = new();

  adam_optimizer_update i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .cmd_i, .element_index_i, .gradient_i,
    .out_valid_o, .out_stall_i, .update_value_o, .divisor_fault_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // accepted beats on both sides
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      sb.note_beat(cmd_e'(cmd_i), element_index_i, gradient_i);
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(update_value_o, divisor_fault_o);
  end

  // receiver: stall pattern picked at random from three modes, plus one long hold-off on request
  initial begin
    int unsigned mode, hold;
    mode = 0;
    hold = 0;
    forever begin
      for (int i = 0; i < 64; i++) begin
        @(posedge clk_i);
        if (hold_req && hold == 0) hold = HoldCycles;
        if (hold != 0) begin
          hold--;
          if (hold == 0) hold_req = 1'b0;
          out_stall_i <= 1'b1;
        end else begin
          case (mode)
            0:       out_stall_i <= 1'b0;
            1:       out_stall_i <= ($urandom_range(0, 3) == 0);
            default: out_stall_i <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
      mode = $urandom_range(0, 2);
    end
  end

  initial begin
    #(4 * 600000);
    $display("Test completed with failures");
    $finish;
  end

  // leaves valid high; the caller lowers it at the end of a burst
  task automatic send_beat(cmd_e c, bit [11:0] idx, bit [31:0] g);
    cmd_i <= c;
    element_index_i <= idx;
    gradient_i <= g;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic end_burst(int unsigned gap);
    if (gap == 0) return;
    in_valid_i <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  task automatic drain();
    end_burst(1);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e r, bit [31:0] d);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= r;
    cfg_data_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(r, d);
    @(posedge clk_i);
  endtask

  task automatic write_all(bit [31:0] lr, bit [31:0] b1, bit [31:0] b2, bit [31:0] eps);
    write_reg(REG_LR, lr);
    write_reg(REG_BETA1, b1);
    write_reg(REG_BETA2, b2);
    write_reg(REG_EPS, eps);
  endtask

  function automatic bit [31:0] rand_gradient();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 255) - 128;
      1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2:       return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic random_beats(int unsigned n);
    int unsigned sent, burst;
    bit [11:0]   idx;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst; i++) begin
        idx = ($urandom_range(0, 9) < 7) ? 12'($urandom_range(0, 15)) : 12'($urandom);
        if ($urandom_range(0, 99) < 8) send_beat(CMD_STEP, '0, $urandom);
        else send_beat(CMD_ELEM, idx, rand_gradient());
        sent++;
      end
      end_burst(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // element before any step: bias divisor zero, all three sign outcomes
    send_beat(CMD_ELEM, 12'd0, 32'h7FFF_FFFF);
    send_beat(CMD_ELEM, 12'd4095, 32'h8000_0000);
    send_beat(CMD_ELEM, 12'd7, 32'd0);
    send_beat(CMD_STEP, 12'd0, 32'd0);
    send_beat(CMD_ELEM, 12'd0, 32'h7FFF_FFFF);
    send_beat(CMD_ELEM, 12'd4095, 32'h8000_0000);
    send_beat(CMD_ELEM, 12'd1, 32'd1);
    send_beat(CMD_ELEM, 12'd2, 32'hFFFF_FFFF);
    send_beat(CMD_ELEM, 12'd3, 32'd0);
    send_beat(CMD_STEP, 12'hFFF, 32'hFFFF_FFFF);
    send_beat(CMD_ELEM, 12'd0, 32'h0100_0000);
    drain();

    // beta1 zero, beta2 near one, no epsilon: tiny gradient on a fresh row
    // gives a zero denominator with m nonzero
    write_all(32'hFF_FFFF, 32'd0, 32'hFF_FFFF, 32'd0);
    send_beat(CMD_STEP, 12'd0, 32'd0);
    send_beat(CMD_ELEM, 12'd100, 32'd1);
    send_beat(CMD_ELEM, 12'd101, 32'hFFFF_FFFF);
    send_beat(CMD_ELEM, 12'd102, 32'd0);
    send_beat(CMD_ELEM, 12'd103, 32'h7FFF_FFFF);
    send_beat(CMD_ELEM, 12'd104, 32'h8000_0000);
    drain();

    // maximum epsilon, beta2 zero
    write_all(32'd0, 32'hFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    send_beat(CMD_ELEM, 12'd100, 32'h7FFF_FFFF);
    send_beat(CMD_STEP, 12'd0, 32'd0);
    send_beat(CMD_ELEM, 12'd100, 32'h8000_0000);
    drain();

    write_all(LrReset, Beta1Reset, Beta2Reset, EpsReset);
    random_beats(130);
    drain();

    // long output hold-off while beats keep coming; more beats than the pipe
    // holds, so it fills and the input stalls
    write_all($urandom, $urandom, $urandom_range(24'hF0_0000, 24'hFF_FFFF), $urandom_range(0, 999));
    hold_req = 1'b1;
    random_beats(230);
    drain();

    write_all(32'hFF_FFFF, $urandom, $urandom, $urandom);
    random_beats(40);
    drain();

    write_all($urandom, 32'hFF_FFFF, 32'hFF_FFFF, 32'd0);
    random_beats(40);
    drain();

    $display("Checked %0d update beats (%0d with divisor fault) from %0d element and %0d step beats.",
             sb.n_checked, sb.n_faults, sb.n_elems, sb.n_steps);
    $display("Covered register extremes, zero divisor and denominator, and a long output hold-off.");
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
